// File: rtl/core/pesc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesc_pkg
// Shared types, constants and helper functions for the pen event to screen
// coordinate converter.
// ----------------------------------------------------------------------------
package pesc_pkg;

    // fixed point and field widths
    localparam int FRACTION_BITS = 8;
    localparam int RAW_BITS      = 24;
    localparam int SPAN_BITS     = 12;
    localparam int OUT_BITS      = 20;
    localparam int PROD_BITS     = RAW_BITS + SPAN_BITS;
    localparam int QUOT_BITS     = SPAN_BITS + FRACTION_BITS;
    localparam int CNT_BITS      = $clog2(QUOT_BITS);

    localparam logic [32:0]         RAW_TOP = (33'd1 << RAW_BITS) - 33'd1;
    localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

    // configuration port
    localparam int CFG_DATA_BITS = 24;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_RAW_X_MAX     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RAW_Y_MAX     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIRROR_X      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIRROR_Y      = 3'd5;

    localparam logic [RAW_BITS-1:0]  RST_RAW_X_MAX     = 24'd20966;
    localparam logic [RAW_BITS-1:0]  RST_RAW_Y_MAX     = 24'd15725;
    localparam logic [SPAN_BITS-1:0] RST_SCREEN_WIDTH  = 12'd1404;
    localparam logic [SPAN_BITS-1:0] RST_SCREEN_HEIGHT = 12'd1872;

    // event classes and codes
    localparam logic [4:0] EVT_SYN = 5'd0;
    localparam logic [4:0] EVT_KEY = 5'd1;
    localparam logic [4:0] EVT_ABS = 5'd3;

    localparam logic [9:0] CODE_ABS_X      = 10'd0;
    localparam logic [9:0] CODE_ABS_Y      = 10'd1;
    localparam logic [9:0] CODE_SYN_REPORT = 10'd0;
    localparam logic [9:0] CODE_TOUCH      = 10'd330;

    typedef struct packed {
        logic [4:0]         event_type;
        logic [9:0]         event_code;
        logic signed [31:0] event_value;
    } event_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] screen_x;
        logic [OUT_BITS-1:0] screen_y;
        logic                pen_down;
    } sample_t;

    typedef struct packed {
        logic start;
        logic invert;
    } scale_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DELIVER
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_DIV,
        SC_FIN
    } scale_phase_t;

    // negative values go to zero, large ones to the top of the raw range
    function automatic logic [RAW_BITS-1:0] sat_raw(input logic signed [31:0] v);
        logic [32:0] ext;
        ext = {1'b0, v};
        if (v[31]) begin
            return '0;
        end else if (ext > RAW_TOP) begin
            return RAW_TOP[RAW_BITS-1:0];
        end else begin
            return v[RAW_BITS-1:0];
        end
    endfunction

    function automatic logic [OUT_BITS-1:0] sat_out(input logic [QUOT_BITS-1:0] v);
        if (64'(v) > 64'(OUT_MAX)) begin
            return OUT_MAX;
        end else begin
            return OUT_BITS'(v);
        end
    endfunction

endpackage

// File: rtl/core/pen_event_to_screen_coords.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pen_event_to_screen_coords
// Turns digitizer input events into rotated, scaled screen samples in
// 1/256 pixel units.
// ----------------------------------------------------------------------------
// Events are taken one per clock while no sample is being computed or handed
// over. A sync report on a dirty frame starts two bit-serial scaling units,
// one per axis, running side by side: a shift-add multiply by the panel span,
// then a restoring division by the raw maximum, a finishing step and a
// hand-over to the result channel, during which s_ready stays low. A finished
// sample sits in an output register, and further events are taken while it
// waits there. There is no clearing pass after reset.
module pen_event_to_screen_coords (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  pesc_pkg::event_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output pesc_pkg::sample_t                   m_data,
    input  logic                                cfg_wr_en,
    input  logic [pesc_pkg::CFG_IDX_BITS-1:0]   cfg_wr_index,
    input  logic [pesc_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data
);

    pesc_pkg::ctrl_state_t state_reg, state_next;

    logic [pesc_pkg::RAW_BITS-1:0]  raw_x_max_reg;
    logic [pesc_pkg::RAW_BITS-1:0]  raw_y_max_reg;
    logic [pesc_pkg::SPAN_BITS-1:0] screen_width_reg;
    logic [pesc_pkg::SPAN_BITS-1:0] screen_height_reg;
    logic                           mirror_x_reg;
    logic                           mirror_y_reg;

    logic [pesc_pkg::RAW_BITS-1:0]  raw_x_reg, raw_x_next;
    logic [pesc_pkg::RAW_BITS-1:0]  raw_y_reg, raw_y_next;
    logic                           contact_reg, contact_next;
    logic                           dirty_reg, dirty_next;
    logic                           m_valid_reg, m_valid_next;
    pesc_pkg::sample_t              m_data_reg, m_data_next;

    logic                           accept;
    logic                           is_abs_x;
    logic                           is_abs_y;
    logic                           is_touch;
    logic                           is_report;
    logic                           trigger;
    logic                           load_out;
    pesc_pkg::scale_req_t           req_x;
    pesc_pkg::scale_req_t           req_y;
    logic                           done_x;
    logic                           done_y;
    logic [pesc_pkg::OUT_BITS-1:0]  result_x;
    logic [pesc_pkg::OUT_BITS-1:0]  result_y;

    assign accept    = s_valid && s_ready;
    assign is_abs_x  = s_data.event_type == pesc_pkg::EVT_ABS
                    && s_data.event_code == pesc_pkg::CODE_ABS_X;
    assign is_abs_y  = s_data.event_type == pesc_pkg::EVT_ABS
                    && s_data.event_code == pesc_pkg::CODE_ABS_Y;
    assign is_touch  = s_data.event_type == pesc_pkg::EVT_KEY
                    && s_data.event_code == pesc_pkg::CODE_TOUCH;
    assign is_report = s_data.event_type == pesc_pkg::EVT_SYN
                    && s_data.event_code == pesc_pkg::CODE_SYN_REPORT;
    assign trigger   = accept && is_report && dirty_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_x_max_reg     <= pesc_pkg::RST_RAW_X_MAX;
            raw_y_max_reg     <= pesc_pkg::RST_RAW_Y_MAX;
            screen_width_reg  <= pesc_pkg::RST_SCREEN_WIDTH;
            screen_height_reg <= pesc_pkg::RST_SCREEN_HEIGHT;
            mirror_x_reg      <= 1'b0;
            mirror_y_reg      <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                pesc_pkg::REG_RAW_X_MAX: begin
                    raw_x_max_reg <= cfg_wr_data[pesc_pkg::RAW_BITS-1:0];
                end
                pesc_pkg::REG_RAW_Y_MAX: begin
                    raw_y_max_reg <= cfg_wr_data[pesc_pkg::RAW_BITS-1:0];
                end
                pesc_pkg::REG_SCREEN_WIDTH: begin
                    screen_width_reg <= cfg_wr_data[pesc_pkg::SPAN_BITS-1:0];
                end
                pesc_pkg::REG_SCREEN_HEIGHT: begin
                    screen_height_reg <= cfg_wr_data[pesc_pkg::SPAN_BITS-1:0];
                end
                pesc_pkg::REG_MIRROR_X: begin
                    mirror_x_reg <= cfg_wr_data[0];
                end
                pesc_pkg::REG_MIRROR_Y: begin
                    mirror_y_reg <= cfg_wr_data[0];
                end
                default: begin
                    mirror_y_reg <= mirror_y_reg;
                end
            endcase
        end
    end

    // latched frame state
    always_comb begin
        raw_x_next   = raw_x_reg;
        raw_y_next   = raw_y_reg;
        contact_next = contact_reg;
        dirty_next   = dirty_reg;
        if (accept) begin
            if (is_abs_x) begin
                raw_x_next = pesc_pkg::sat_raw(s_data.event_value);
                dirty_next = 1'b1;
            end
            if (is_abs_y) begin
                raw_y_next = pesc_pkg::sat_raw(s_data.event_value);
                dirty_next = 1'b1;
            end
            if (is_touch) begin
                contact_next = s_data.event_value != '0;
                dirty_next   = 1'b1;
            end
            if (trigger) begin
                dirty_next = 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pesc_pkg::ST_IDLE: begin
                if (trigger) begin
                    state_next = pesc_pkg::ST_CALC;
                end
            end
            pesc_pkg::ST_CALC: begin
                if (done_x) begin
                    state_next = pesc_pkg::ST_DELIVER;
                end
            end
            pesc_pkg::ST_DELIVER: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = pesc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pesc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            pesc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            pesc_pkg::ST_CALC: begin
                s_ready = 1'b0;
            end
            pesc_pkg::ST_DELIVER: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // portrait rotation: screen x from raw y, screen y inverted from raw x; each mirror bit flips its axis
    assign req_x.start  = trigger;
    assign req_x.invert = mirror_x_reg;
    assign req_y.start  = trigger;
    assign req_y.invert = !mirror_y_reg;

    pesc_scaler u_scale_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_x),
        .raw     (raw_y_reg),
        .max_val (raw_y_max_reg),
        .span    (screen_width_reg),
        .done    (done_x),
        .result  (result_x)
    );

    pesc_scaler u_scale_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_y),
        .raw     (raw_x_reg),
        .max_val (raw_x_max_reg),
        .span    (screen_height_reg),
        .done    (done_y),
        .result  (result_y)
    );

    // output register, freed by a transfer on the result side
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load_out) begin
            m_valid_next         = 1'b1;
            m_data_next.screen_x = result_x;
            m_data_next.screen_y = result_y;
            m_data_next.pen_down = contact_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pesc_pkg::ST_IDLE;
            raw_x_reg   <= '0;
            raw_y_reg   <= '0;
            contact_reg <= 1'b0;
            dirty_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            raw_x_reg   <= raw_x_next;
            raw_y_reg   <= raw_y_next;
            contact_reg <= contact_next;
            dirty_reg   <= dirty_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_axes_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        done_x == done_y)
        else $error("axis scalers out of step");

    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        done_x |-> state_reg == pesc_pkg::ST_CALC)
        else $error("scaler finished outside calculation");

    a_trigger_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        trigger |=> !s_ready && !dirty_reg)
        else $error("input not stalled or frame still dirty after report");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid_reg)
        else $error("sample loaded without valid");

endmodule

// File: rtl/core/pesc_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesc_scaler
// Bit-serial scaling unit: raw * span * 2^F / max, floor or ceil-and-invert,
// built from a shift-add multiplier followed by a restoring divider.
// ----------------------------------------------------------------------------
module pesc_scaler (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pesc_pkg::scale_req_t           req,
    input  logic [pesc_pkg::RAW_BITS-1:0]  raw,
    input  logic [pesc_pkg::RAW_BITS-1:0]  max_val,
    input  logic [pesc_pkg::SPAN_BITS-1:0] span,
    output logic                           done,
    output logic [pesc_pkg::OUT_BITS-1:0]  result
);

    pesc_pkg::scale_phase_t phase_reg, phase_next;

    logic [pesc_pkg::CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic                           invert_reg, invert_next;
    logic [pesc_pkg::RAW_BITS-1:0]  divisor_reg, divisor_next;
    logic [pesc_pkg::RAW_BITS-1:0]  mcand_reg, mcand_next;
    logic [pesc_pkg::SPAN_BITS-1:0] mplier_reg, mplier_next;
    logic [pesc_pkg::SPAN_BITS-1:0] span_reg, span_next;
    logic [pesc_pkg::PROD_BITS-1:0] prod_reg, prod_next;
    logic [pesc_pkg::RAW_BITS-1:0]  rem_reg, rem_next;
    logic [pesc_pkg::QUOT_BITS-1:0] quot_reg, quot_next;
    logic [pesc_pkg::OUT_BITS-1:0]  result_reg, result_next;

    logic [pesc_pkg::RAW_BITS-1:0]  divisor_clamped;
    logic [pesc_pkg::RAW_BITS-1:0]  raw_clamped;
    logic [pesc_pkg::PROD_BITS-1:0] prod_step;
    logic [pesc_pkg::RAW_BITS:0]    trial;
    logic [pesc_pkg::RAW_BITS:0]    trial_diff;
    logic                           trial_ge;
    logic [pesc_pkg::QUOT_BITS-1:0] full_scale;
    logic [pesc_pkg::QUOT_BITS-1:0] scaled;
    logic                           mul_last;
    logic                           div_last;

    // zero max counts as one, raw clamps to max
    assign divisor_clamped = (max_val == '0) ? pesc_pkg::RAW_BITS'(1) : max_val;
    assign raw_clamped     = (raw > divisor_clamped) ? divisor_clamped : raw;

    // msb-first shift-add
    assign prod_step = {prod_reg[pesc_pkg::PROD_BITS-2:0], 1'b0}
                     + (mplier_reg[pesc_pkg::SPAN_BITS-1]
                        ? pesc_pkg::PROD_BITS'(mcand_reg) : '0);

    // restoring division step, dividend bits shift out of the quotient register
    assign trial      = {rem_reg, quot_reg[pesc_pkg::QUOT_BITS-1]};
    assign trial_ge   = trial >= {1'b0, divisor_reg};
    assign trial_diff = trial - {1'b0, divisor_reg};

    assign full_scale = pesc_pkg::QUOT_BITS'(span_reg) << pesc_pkg::FRACTION_BITS;
    // full - ceil(q) folded into one expression
    assign scaled = invert_reg
                  ? full_scale - quot_reg - pesc_pkg::QUOT_BITS'(rem_reg != '0)
                  : quot_reg;

    assign mul_last = cnt_reg == pesc_pkg::CNT_BITS'(pesc_pkg::SPAN_BITS - 1);
    assign div_last = cnt_reg == pesc_pkg::CNT_BITS'(pesc_pkg::QUOT_BITS - 1);

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            pesc_pkg::SC_IDLE: begin
                if (req.start) begin
                    phase_next = pesc_pkg::SC_MUL;
                end
            end
            pesc_pkg::SC_MUL: begin
                if (mul_last) begin
                    phase_next = pesc_pkg::SC_DIV;
                end
            end
            pesc_pkg::SC_DIV: begin
                if (div_last) begin
                    phase_next = pesc_pkg::SC_FIN;
                end
            end
            pesc_pkg::SC_FIN: begin
                phase_next = pesc_pkg::SC_IDLE;
            end
            default: begin
                phase_next = pesc_pkg::SC_IDLE;
            end
        endcase
    end

    always_comb begin
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        invert_next  = invert_reg;
        divisor_next = divisor_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        span_next    = span_reg;
        prod_next    = prod_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        result_next  = result_reg;
        case (phase_reg)
            pesc_pkg::SC_IDLE: begin
                if (req.start) begin
                    cnt_next     = '0;
                    invert_next  = req.invert;
                    divisor_next = divisor_clamped;
                    mcand_next   = raw_clamped;
                    mplier_next  = span;
                    span_next    = span;
                    prod_next    = '0;
                end
            end
            pesc_pkg::SC_MUL: begin
                prod_next   = prod_step;
                mplier_next = {mplier_reg[pesc_pkg::SPAN_BITS-2:0], 1'b0};
                if (mul_last) begin
                    cnt_next  = '0;
                    // high part of the dividend is already below the divisor
                    rem_next  = pesc_pkg::RAW_BITS'(prod_step >> pesc_pkg::SPAN_BITS);
                    quot_next = pesc_pkg::QUOT_BITS'(prod_step[pesc_pkg::SPAN_BITS-1:0])
                              << pesc_pkg::FRACTION_BITS;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            pesc_pkg::SC_DIV: begin
                rem_next  = trial_ge ? trial_diff[pesc_pkg::RAW_BITS-1:0]
                                     : trial[pesc_pkg::RAW_BITS-1:0];
                quot_next = {quot_reg[pesc_pkg::QUOT_BITS-2:0], trial_ge};
                cnt_next  = cnt_reg + 1'b1;
            end
            pesc_pkg::SC_FIN: begin
                result_next = pesc_pkg::sat_out(scaled);
                done_next   = 1'b1;
            end
            default: begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= pesc_pkg::SC_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        invert_reg  <= invert_next;
        divisor_reg <= divisor_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        span_reg    <= span_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == pesc_pkg::SC_DIV |-> rem_reg < divisor_reg)
        else $error("partial remainder not below divisor");

    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == pesc_pkg::SC_MUL |-> divisor_reg != '0)
        else $error("zero divisor in use");

    a_done_after_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(phase_reg) == pesc_pkg::SC_FIN)
        else $error("done without a finishing step");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pen_event_to_screen_coords. A short table of
// directed events is followed by random event frames under several register
// settings. Each result transfer is compared with its table row's sample or
// with a behavioural predictor of the rotation, scaling and mirroring.
// ----------------------------------------------------------------------------
module tb_top;
    import pesc_pkg::*;

    localparam int          DRAIN_CYCLES = 48;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int          PHASE_ITEMS  = 190;
    localparam int          NUM_PHASES   = 10;

    typedef struct {
        event_t  ev;
        bit      typed;
        sample_t want;
    } stim_row_t;

    logic                     aclk;
    logic                     aresetn      = 1'b0;
    logic                     s_valid      = 1'b0;
    logic                     s_ready;
    event_t                   s_data       = '0;
    logic                     m_valid;
    logic                     m_ready      = 1'b0;
    sample_t                  m_data;
    logic                     cfg_wr_en    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data  = '0;

    // predictor copy of the registers and the frame state
    logic [RAW_BITS-1:0]  cfg_x_max;
    logic [RAW_BITS-1:0]  cfg_y_max;
    logic [SPAN_BITS-1:0] cfg_width;
    logic [SPAN_BITS-1:0] cfg_height;
    bit                   cfg_mirror_x;
    bit                   cfg_mirror_y;
    logic [RAW_BITS-1:0]  lat_x;
    logic [RAW_BITS-1:0]  lat_y;
    bit                   pen_contact;
    bit                   frame_dirty;

    sample_t     expected_samples[$];
    stim_row_t   dir_rows[$];
    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int          burst_left     = 0;
    bit          use_gaps       = 1'b1;

    pen_event_to_screen_coords u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d samples outstanding", $time,
                     expected_samples.size());
            $display("pen_event_to_screen_coords test failed");
            $finish;
        end
    end

    // negative goes to zero, anything past the raw range to its top
    function automatic logic [RAW_BITS-1:0] clip_raw(input logic signed [31:0] v);
        if (v < 0) begin
            return '0;
        end else if (v > 32'sh00FF_FFFF) begin
            return '1;
        end
        return v[RAW_BITS-1:0];
    endfunction

    // floor or ceil of raw * span * 2^FRACTION_BITS / max, raw clamped to max
    function automatic longint unsigned scale_axis(input logic [RAW_BITS-1:0] raw,
                                                   input logic [RAW_BITS-1:0] maxv,
                                                   input logic [SPAN_BITS-1:0] span,
                                                   input bit round_up);
        longint unsigned m, r, num, q;
        m   = (maxv == '0) ? 64'd1 : 64'(maxv);
        r   = (64'(raw) > m) ? m : 64'(raw);
        num = (r * 64'(span)) << FRACTION_BITS;
        q   = num / m;
        if (round_up && (num % m) != 0) begin
            q++;
        end
        return q;
    endfunction

    function automatic bit predict_event(input event_t ev, output sample_t smp);
        longint unsigned full_w, full_h, sx, sy;
        smp = '0;
        if (ev.event_type == EVT_ABS) begin
            if (ev.event_code == CODE_ABS_X) begin
                lat_x       = clip_raw(ev.event_value);
                frame_dirty = 1'b1;
            end else if (ev.event_code == CODE_ABS_Y) begin
                lat_y       = clip_raw(ev.event_value);
                frame_dirty = 1'b1;
            end
            return 1'b0;
        end
        if (ev.event_type == EVT_KEY) begin
            if (ev.event_code == CODE_TOUCH) begin
                pen_contact = (ev.event_value != 0);
                frame_dirty = 1'b1;
            end
            return 1'b0;
        end
        if (ev.event_type != EVT_SYN || ev.event_code != CODE_SYN_REPORT || !frame_dirty) begin
            return 1'b0;
        end
        frame_dirty = 1'b0;
        full_w = 64'(cfg_width) << FRACTION_BITS;
        full_h = 64'(cfg_height) << FRACTION_BITS;
        // landscape digitizer: screen x follows raw y, screen y runs against raw x unless mirror y is set
        if (cfg_mirror_x) begin
            sx = full_w - scale_axis(lat_y, cfg_y_max, cfg_width, 1'b1);
        end else begin
            sx = scale_axis(lat_y, cfg_y_max, cfg_width, 1'b0);
        end
        if (cfg_mirror_y) begin
            sy = scale_axis(lat_x, cfg_x_max, cfg_height, 1'b0);
        end else begin
            sy = full_h - scale_axis(lat_x, cfg_x_max, cfg_height, 1'b1);
        end
        smp.screen_x = (sx > 64'(OUT_MAX)) ? OUT_MAX : sx[OUT_BITS-1:0];
        smp.screen_y = (sy > 64'(OUT_MAX)) ? OUT_MAX : sy[OUT_BITS-1:0];
        smp.pen_down = pen_contact;
        return 1'b1;
    endfunction

    always @(posedge aclk) begin : sample_check
        sample_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected sample x=%0d y=%0d pen=%0b", $time,
                         m_data.screen_x, m_data.screen_y, m_data.pen_down);
                mismatch_count++;
            end else begin
                want = expected_samples.pop_front();
                if (m_data.screen_x !== want.screen_x) begin
                    $display("%0t: screen_x expected %0d actual %0d", $time,
                             want.screen_x, m_data.screen_x);
                    mismatch_count++;
                end
                if (m_data.screen_y !== want.screen_y) begin
                    $display("%0t: screen_y expected %0d actual %0d", $time,
                             want.screen_y, m_data.screen_y);
                    mismatch_count++;
                end
                if (m_data.pen_down !== want.pen_down) begin
                    $display("%0t: pen_down expected %0b actual %0b", $time,
                             want.pen_down, m_data.pen_down);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver stalls follow a mode that changes every so often
    initial begin : ready_pattern
        int mode;
        int run_len;
        int k;
        forever begin
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(20, 200);
            for (k = 0; k < run_len; k++) begin
                @(posedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ((k % 5) == 4);
                    default: m_ready <= ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    task automatic push_event(input event_t ev, input bit typed, input sample_t want);
        sample_t smp;
        int      gap;
        bit      drain;
        s_valid <= 1'b1;
        s_data  <= ev;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        // transfer taken at this edge
        if (predict_event(ev, smp)) begin
            expected_samples.push_back(typed ? want : smp);
        end
        gap   = 0;
        drain = ($urandom_range(0, 299) == 0);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            if (use_gaps) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 45) : $urandom_range(1, 5);
            end
        end
        // a drain always brings a gap with valid low
        if (drain && gap == 0) begin
            gap = 1;
        end
        if (gap > 0 || drain) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            while (drain && expected_samples.size() != 0) @(posedge aclk);
        end
    endtask

    task automatic send_event(input logic [4:0] t, input logic [9:0] c, input logic [31:0] v);
        event_t ev;
        ev.event_type  = t;
        ev.event_code  = c;
        ev.event_value = v;
        push_event(ev, 1'b0, '0);
    endtask

    function automatic void add_row(input logic [4:0] t, input logic [9:0] c,
                                    input logic [31:0] v, input bit typed,
                                    input logic [OUT_BITS-1:0] x,
                                    input logic [OUT_BITS-1:0] y, input logic pen);
        stim_row_t row;
        row.ev.event_type  = t;
        row.ev.event_code  = c;
        row.ev.event_value = v;
        row.typed          = typed;
        row.want.screen_x  = x;
        row.want.screen_y  = y;
        row.want.pen_down  = pen;
        dir_rows.push_back(row);
    endfunction

    // wait for every sample, then for the block to finish any work in flight
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        case (idx)
            REG_RAW_X_MAX:     cfg_x_max    = data[RAW_BITS-1:0];
            REG_RAW_Y_MAX:     cfg_y_max    = data[RAW_BITS-1:0];
            REG_SCREEN_WIDTH:  cfg_width    = data[SPAN_BITS-1:0];
            REG_SCREEN_HEIGHT: cfg_height   = data[SPAN_BITS-1:0];
            REG_MIRROR_X:      cfg_mirror_x = data[0];
            REG_MIRROR_Y:      cfg_mirror_y = data[0];
            default: ;
        endcase
    endtask

    // narrow registers get junk in the unused upper data bits
    task automatic load_setting(input logic [RAW_BITS-1:0] xm, input logic [RAW_BITS-1:0] ym,
                                input logic [SPAN_BITS-1:0] w, input logic [SPAN_BITS-1:0] h,
                                input bit mx, input bit my);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(REG_RAW_X_MAX, xm);
        write_reg(REG_RAW_Y_MAX, ym);
        write_reg(REG_SCREEN_WIDTH, {junk[11:0], w});
        write_reg(REG_SCREEN_HEIGHT, {junk[23:12], h});
        write_reg(REG_MIRROR_X, {junk[22:0], mx});
        write_reg(REG_MIRROR_Y, {junk[31:9], my});
    endtask

    function automatic logic [31:0] pick_axis(input logic [RAW_BITS-1:0] maxv);
        logic [31:0] m;
        m = (maxv == '0) ? 32'd1 : 32'(maxv);
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return m;
            2: return {1'b1, 31'($urandom)};
            3: return $urandom_range(m, 32'h7FFF_FFFF);
            4: return $urandom;
            default: return $urandom_range(0, m);
        endcase
    endfunction

    task automatic run_frames(input int n_items);
        int          sent;
        int          k;
        logic [9:0]  code;
        logic [31:0] v;
        sent = 0;
        while (sent < n_items) begin
            k = $urandom_range(0, 99);
            if (k < 80) begin
                if ($urandom_range(0, 3) != 0) begin
                    send_event(EVT_ABS, CODE_ABS_X, pick_axis(cfg_x_max));
                    sent++;
                end
                if ($urandom_range(0, 3) != 0) begin
                    send_event(EVT_ABS, CODE_ABS_Y, pick_axis(cfg_y_max));
                    sent++;
                end
                if ($urandom_range(0, 2) == 0) begin
                    v = $urandom_range(0, 1) ? 32'd0 : $urandom;
                    send_event(EVT_KEY, CODE_TOUCH, v);
                    sent++;
                end
                send_event(EVT_SYN, CODE_SYN_REPORT, $urandom);
                sent++;
            end else if (k < 90) begin
                // noise, mostly ignored by the block
                case ($urandom_range(0, 3))
                    0: code = CODE_TOUCH;
                    1: code = CODE_ABS_Y + 10'd1;
                    default: code = 10'($urandom_range(0, 1023));
                endcase
                send_event(5'($urandom_range(0, 31)), code, $urandom);
                sent++;
            end else begin
                // broken frames: lone report or axis data with no report
                case ($urandom_range(0, 2))
                    0: send_event(EVT_SYN, CODE_SYN_REPORT, $urandom);
                    1: send_event(EVT_ABS, CODE_ABS_X, pick_axis(cfg_x_max));
                    default: send_event(EVT_ABS, CODE_ABS_Y, pick_axis(cfg_y_max));
                endcase
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        int p;
        cfg_x_max    = RST_RAW_X_MAX;
        cfg_y_max    = RST_RAW_Y_MAX;
        cfg_width    = RST_SCREEN_WIDTH;
        cfg_height   = RST_SCREEN_HEIGHT;
        cfg_mirror_x = 1'b0;
        cfg_mirror_y = 1'b0;
        lat_x        = '0;
        lat_y        = '0;
        pen_contact  = 1'b0;
        frame_dirty  = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed events under the reset setting
        add_row(EVT_SYN, CODE_SYN_REPORT, 32'd0, 1'b0, '0, '0, 1'b0);
        add_row(EVT_ABS, CODE_ABS_X, 32'd0, 1'b0, '0, '0, 1'b0);
        add_row(EVT_ABS, CODE_ABS_Y, 32'd0, 1'b0, '0, '0, 1'b0);
        add_row(EVT_KEY, CODE_TOUCH, 32'd1, 1'b0, '0, '0, 1'b0);
        add_row(EVT_SYN, CODE_SYN_REPORT, 32'd0, 1'b1, 20'd0, 20'd479232, 1'b1);
        add_row(EVT_ABS, CODE_ABS_X, 32'd20966, 1'b0, '0, '0, 1'b0);
        add_row(EVT_ABS, CODE_ABS_Y, 32'd15725, 1'b0, '0, '0, 1'b0);
        add_row(EVT_SYN, CODE_SYN_REPORT, 32'd0, 1'b1, 20'd359424, 20'd0, 1'b1);
        add_row(EVT_ABS, CODE_ABS_X, 32'h8000_0000, 1'b0, '0, '0, 1'b0);
        add_row(EVT_ABS, CODE_ABS_Y, 32'h7FFF_FFFF, 1'b0, '0, '0, 1'b0);
        add_row(EVT_KEY, CODE_TOUCH, 32'd0, 1'b0, '0, '0, 1'b0);
        add_row(EVT_SYN, CODE_SYN_REPORT, 32'd0, 1'b1, 20'd359424, 20'd479232, 1'b0);
        add_row(EVT_KEY, CODE_TOUCH, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0);
        add_row(EVT_SYN, CODE_SYN_REPORT, 32'd0, 1'b1, 20'd359424, 20'd479232, 1'b1);
        add_row(EVT_ABS, CODE_ABS_Y + 10'd1, 32'd5, 1'b0, '0, '0, 1'b0);
        add_row(EVT_KEY, CODE_TOUCH + 10'd1, 32'd1, 1'b0, '0, '0, 1'b0);
        add_row(EVT_KEY + 5'd1, CODE_ABS_X, 32'd7, 1'b0, '0, '0, 1'b0);
        add_row(EVT_SYN, CODE_SYN_REPORT + 10'd1, 32'd0, 1'b0, '0, '0, 1'b0);
        add_row('1, '1, '1, 1'b0, '0, '0, 1'b0);
        add_row(EVT_SYN, CODE_SYN_REPORT, 32'd0, 1'b0, '0, '0, 1'b0);
        add_row(EVT_ABS, CODE_ABS_X, 32'd10483, 1'b0, '0, '0, 1'b0);
        add_row(EVT_ABS, CODE_ABS_Y, 32'h0100_0000, 1'b0, '0, '0, 1'b0);
        add_row(EVT_SYN, CODE_SYN_REPORT, 32'd0, 1'b0, '0, '0, 1'b0);
        foreach (dir_rows[i]) begin
            push_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                0: begin
                    load_setting(RST_RAW_X_MAX, RST_RAW_Y_MAX, RST_SCREEN_WIDTH,
                                 RST_SCREEN_HEIGHT, 1'b0, 1'b0);
                    // indexes past the register list must change nothing
                    write_reg(REG_MIRROR_Y + 3'd1, CFG_DATA_BITS'($urandom));
                    write_reg('1, CFG_DATA_BITS'($urandom));
                end
                1: load_setting('1, '1, '1, '1, 1'b1, 1'b1);
                2: load_setting(24'd1, 24'd1, 12'd1, 12'd1, 1'b1, 1'b0);
                3: load_setting('0, '0, '0, '0, 1'b0, 1'b1);
                default: begin
                    load_setting(RAW_BITS'($urandom_range(0, 1) ? $urandom_range(1, 255)
                                                : $urandom_range(1, 24'hFF_FFFF)),
                                 RAW_BITS'($urandom_range(0, 1) ? $urandom_range(1, 255)
                                                : $urandom_range(1, 24'hFF_FFFF)),
                                 SPAN_BITS'($urandom_range(1, 4095)),
                                 SPAN_BITS'($urandom_range(1, 4095)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            endcase
            cfg_wr_en <= 1'b0;
            use_gaps  = ((p % 4) != 2);
            run_frames(PHASE_ITEMS);
        end

        settle();
        if (mismatch_count == 0) begin
            $display("pen_event_to_screen_coords test passed");
        end else begin
            $display("pen_event_to_screen_coords test failed");
        end
        $finish;
    end

endmodule
